### rtl/segment_tree_range_max_defines.svh
// ----------------------------------------------------------------------------
// segment tree range maximum: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TREE_RANGE_MAX_DEFINES_SVH
`define SEGMENT_TREE_RANGE_MAX_DEFINES_SVH

// antecedent and consequent in the same cycle
`define STMR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// consequent in the cycle after the antecedent
`define STMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

### rtl/stmr_pkg.sv
// ----------------------------------------------------------------------------
// stmr_pkg
// shared widths, micro-op codes and control word layout
// ----------------------------------------------------------------------------
package stmr_pkg;

   localparam int LEAVES_MAX_DEFAULT = 16384;
   localparam int VAL_W              = 32;
   localparam int POS_W              = 14;
   localparam int LC_W               = 15;
   localparam int STEP_W             = 4;

   typedef logic [STEP_W-1:0] step_type;

   // datapath actions
   typedef enum logic [3:0] {
      A_NONE,
      A_CLEAR,
      A_LOAD,
      A_W_DESC,
      A_W_LEAF,
      A_RD_SIB,
      A_W_UP,
      A_SPLIT,
      A_DISJ,
      A_RD_NODE,
      A_ACC,
      A_POP,
      A_RESPOND
   } act_type;

   // jump conditions
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NOT_CLR_DONE,
      C_NOT_START,
      C_QUERY,
      C_POS_OUT,
      C_NOT_LEAF,
      C_ROOT,
      C_NOT_ROOT,
      C_PARTIAL,
      C_DISJOINT,
      C_NOT_EMPTY
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic clr_done;
      logic query;
      logic pos_out;
      logic leaf;
      logic root;
      logic partial;
      logic disjoint;
      logic stack_empty;
   } status_type;

endpackage

### rtl/stmr_sequencer.sv
// ----------------------------------------------------------------------------
// stmr_sequencer
// step counter, control store and conditional jumps
// ----------------------------------------------------------------------------
module stmr_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  stmr_pkg::status_type   status,
   output stmr_pkg::ctrl_word_type ctrl,
   output logic                   busy
);
   import stmr_pkg::*;

   localparam step_type S_CLEAR    = 4'd0;
   localparam step_type S_IDLE     = 4'd1;
   localparam step_type S_DISPATCH = 4'd2;
   localparam step_type S_W_CHECK  = 4'd3;
   localparam step_type S_W_DESC   = 4'd4;
   localparam step_type S_W_LEAF   = 4'd5;
   localparam step_type S_W_SIB    = 4'd6;
   localparam step_type S_W_UP     = 4'd7;
   localparam step_type S_W_END    = 4'd8;
   localparam step_type S_Q_TEST   = 4'd9;
   localparam step_type S_Q_CLASS  = 4'd10;
   localparam step_type S_Q_READ   = 4'd11;
   localparam step_type S_Q_ACC    = 4'd12;
   localparam step_type S_Q_POP    = 4'd13;
   localparam step_type S_Q_DONE   = 4'd14;

   step_type step_ff;
   step_type step_in;
   logic     cond_true;

   // control store: action, condition, jump target
   function automatic ctrl_word_type ucode(input step_type s);
      ctrl_word_type w;
      unique case (s)
         S_CLEAR:    w = '{A_CLEAR,   C_NOT_CLR_DONE, S_CLEAR};
         S_IDLE:     w = '{A_LOAD,    C_NOT_START,    S_IDLE};
         S_DISPATCH: w = '{A_NONE,    C_QUERY,        S_Q_TEST};
         S_W_CHECK:  w = '{A_NONE,    C_POS_OUT,      S_IDLE};
         S_W_DESC:   w = '{A_W_DESC,  C_NOT_LEAF,     S_W_DESC};
         S_W_LEAF:   w = '{A_W_LEAF,  C_ROOT,         S_IDLE};
         S_W_SIB:    w = '{A_RD_SIB,  C_NEVER,        S_IDLE};
         S_W_UP:     w = '{A_W_UP,    C_NOT_ROOT,     S_W_SIB};
         S_W_END:    w = '{A_NONE,    C_ALWAYS,       S_IDLE};
         S_Q_TEST:   w = '{A_SPLIT,   C_PARTIAL,      S_Q_TEST};
         S_Q_CLASS:  w = '{A_DISJ,    C_DISJOINT,     S_Q_POP};
         S_Q_READ:   w = '{A_RD_NODE, C_NEVER,        S_IDLE};
         S_Q_ACC:    w = '{A_ACC,     C_NEVER,        S_IDLE};
         S_Q_POP:    w = '{A_POP,     C_NOT_EMPTY,    S_Q_TEST};
         S_Q_DONE:   w = '{A_RESPOND, C_ALWAYS,       S_IDLE};
         default:    w = '{A_NONE,    C_ALWAYS,       S_IDLE};
      endcase
      return w;
   endfunction

   assign ctrl = ucode(step_ff);
   assign busy = (step_ff != S_IDLE);

   always_comb begin
      case (ctrl.cond)
         C_NEVER:        cond_true = 1'b0;
         C_ALWAYS:       cond_true = 1'b1;
         C_NOT_CLR_DONE: cond_true = !status.clr_done;
         C_NOT_START:    cond_true = !start;
         C_QUERY:        cond_true = status.query;
         C_POS_OUT:      cond_true = status.pos_out;
         C_NOT_LEAF:     cond_true = !status.leaf;
         C_ROOT:         cond_true = status.root;
         C_NOT_ROOT:     cond_true = !status.root;
         C_PARTIAL:      cond_true = status.partial;
         C_DISJOINT:     cond_true = status.disjoint;
         C_NOT_EMPTY:    cond_true = !status.stack_empty;
         default:        cond_true = 1'b1;
      endcase
      step_in = cond_true ? ctrl.target : step_ff + step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### rtl/stmr_datapath.sv
// ----------------------------------------------------------------------------
// stmr_datapath
// node memory, frame registers, frame stack and result register
// ----------------------------------------------------------------------------
module stmr_datapath #(
   parameter int LEAVES_MAX = stmr_pkg::LEAVES_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  stmr_pkg::ctrl_word_type           ctrl,
   output stmr_pkg::status_type              status,
   input  logic                              req_op,
   input  logic        [stmr_pkg::POS_W-1:0] req_position,
   input  logic signed [stmr_pkg::VAL_W-1:0] req_value_in,
   input  logic        [stmr_pkg::POS_W-1:0] req_range_low,
   input  logic        [stmr_pkg::POS_W-1:0] req_range_high,
   input  logic                              csr_write_en,
   input  logic        [stmr_pkg::LC_W-1:0]  csr_write_data,
   output logic                              rsp_strobe,
   output logic signed [stmr_pkg::VAL_W-1:0] rsp_max_value
);
   import stmr_pkg::*;

   localparam int PW    = $clog2(LEAVES_MAX);
   localparam int NW    = PW + 1;
   localparam int NODES = 2 ** NW;
   localparam int CW    = (PW > POS_W) ? PW : POS_W;
   localparam int LMW   = $clog2(LEAVES_MAX + 1);
   localparam int LW    = (LMW > LC_W) ? LMW : LC_W;
   localparam int SD    = PW + 1;
   localparam int SIW   = $clog2(SD);
   localparam int SPW   = $clog2(SD + 1);

   // node memory
   logic signed [VAL_W-1:0] mem [NODES];
   logic                    mem_we;
   logic                    mem_re;
   logic        [NW-1:0]    mem_wa;
   logic        [NW-1:0]    mem_ra;
   logic signed [VAL_W-1:0] mem_wd;
   logic signed [VAL_W-1:0] rdata_ff;

   // frame stack
   logic [PW-1:0] stk_lo   [SD];
   logic [PW-1:0] stk_hi   [SD];
   logic [NW-1:0] stk_node [SD];
   logic          stk_we;

   logic [LC_W-1:0]         leaf_count_ff, leaf_count_in;
   logic [NW-1:0]           clr_ff, clr_in;
   logic [SPW-1:0]          sp_ff, sp_in;
   logic                    acc_vld_ff, acc_vld_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic                    op_ff, op_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [POS_W-1:0]        ql_ff, ql_in;
   logic [POS_W-1:0]        qh_ff, qh_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic signed [VAL_W-1:0] acc_ff, acc_in;
   logic signed [VAL_W-1:0] rsp_val_ff, rsp_val_in;
   logic [PW-1:0]           lo_ff, lo_in;
   logic [PW-1:0]           hi_ff, hi_in;
   logic [NW-1:0]           node_ff, node_in;

   logic [LW-1:0]           lc_ext, lc_m1;
   logic [PW-1:0]           span_end;
   logic [PW:0]             mid_sum;
   logic [PW-1:0]           mid, mid_p1;
   logic [CW-1:0]           lo_x, hi_x, mid_x, pos_x, ql_x, qh_x;
   logic [NW-1:0]           left_child, right_child, parent, sibling, node_m1;
   logic [SPW-1:0]          sp_m1;
   logic [SIW-1:0]          top_idx, push_idx;
   logic                    covered;
   logic signed [VAL_W-1:0] up_val;

   function automatic logic signed [VAL_W-1:0] merge(
      input logic                    vld,
      input logic signed [VAL_W-1:0] a,
      input logic signed [VAL_W-1:0] b
   );
      return (vld && (a > b)) ? a : b;
   endfunction

   // effective last position: zero counts as one, large counts saturate
   assign lc_ext   = LW'(leaf_count_ff);
   assign lc_m1    = lc_ext - LW'(1);
   assign span_end = (lc_ext == '0) ? '0 :
                     (lc_ext > LW'(LEAVES_MAX)) ? PW'(LEAVES_MAX - 1) : lc_m1[PW-1:0];

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[PW:1];
   assign mid_p1  = mid + PW'(1);

   assign lo_x  = CW'(lo_ff);
   assign hi_x  = CW'(hi_ff);
   assign mid_x = CW'(mid);
   assign pos_x = CW'(pos_ff);
   assign ql_x  = CW'(ql_ff);
   assign qh_x  = CW'(qh_ff);

   assign left_child  = {node_ff[NW-2:0], 1'b1};
   assign right_child = {node_ff[NW-2:0], 1'b0} + NW'(2);
   assign node_m1     = node_ff - NW'(1);
   assign parent      = {1'b0, node_m1[NW-1:1]};
   assign sibling     = node_ff[0] ? node_ff + NW'(1) : node_m1;

   assign sp_m1    = sp_ff - SPW'(1);
   assign top_idx  = sp_m1[SIW-1:0];
   assign push_idx = sp_ff[SIW-1:0];

   assign covered = (ql_x <= lo_x) && (qh_x >= hi_x);
   assign up_val  = (acc_ff > rdata_ff) ? acc_ff : rdata_ff;

   always_comb begin
      status.clr_done    = &clr_ff;
      status.query       = op_ff;
      status.pos_out     = pos_x > hi_x;
      status.leaf        = lo_ff == hi_ff;
      status.root        = node_ff == '0;
      status.disjoint    = (ql_x > hi_x) || (qh_x < lo_x);
      status.partial     = !status.disjoint && !covered;
      status.stack_empty = sp_ff == '0;
   end

   always_comb begin
      leaf_count_in = csr_write_en ? csr_write_data : leaf_count_ff;
      clr_in        = clr_ff;
      sp_in         = sp_ff;
      acc_vld_in    = acc_vld_ff;
      rsp_strobe_in = 1'b0;
      rsp_val_in    = rsp_val_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      ql_in         = ql_ff;
      qh_in         = qh_ff;
      val_in        = val_ff;
      acc_in        = acc_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      node_in       = node_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_wa        = node_ff;
      mem_ra        = node_ff;
      mem_wd        = val_ff;
      stk_we        = 1'b0;
      unique case (ctrl.act)
         A_NONE: begin
         end
         A_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = -32'sd1;
            clr_in = clr_ff + NW'(1);
         end
         A_LOAD: begin
            op_in      = req_op;
            pos_in     = req_position;
            val_in     = req_value_in;
            ql_in      = req_range_low;
            qh_in      = req_range_high;
            lo_in      = '0;
            hi_in      = span_end;
            node_in    = '0;
            sp_in      = '0;
            acc_vld_in = 1'b0;
         end
         A_W_DESC: begin
            if (!status.leaf) begin
               if (pos_x <= mid_x) begin
                  hi_in   = mid;
                  node_in = left_child;
               end else begin
                  lo_in   = mid_p1;
                  node_in = right_child;
               end
            end
         end
         A_W_LEAF: begin
            mem_we = 1'b1;
            mem_wd = val_ff;
            acc_in = val_ff;
         end
         A_RD_SIB: begin
            mem_re  = 1'b1;
            mem_ra  = sibling;
            node_in = parent;
         end
         A_W_UP: begin
            mem_we = 1'b1;
            mem_wd = up_val;
            acc_in = up_val;
         end
         A_SPLIT: begin
            if (status.partial) begin
               stk_we  = 1'b1;
               sp_in   = sp_ff + SPW'(1);
               hi_in   = mid;
               node_in = left_child;
            end
         end
         A_DISJ: begin
            if (status.disjoint) begin
               acc_in     = merge(acc_vld_ff, acc_ff, -32'sd1);
               acc_vld_in = 1'b1;
            end
         end
         A_RD_NODE: begin
            mem_re = 1'b1;
         end
         A_ACC: begin
            acc_in     = merge(acc_vld_ff, acc_ff, rdata_ff);
            acc_vld_in = 1'b1;
         end
         A_POP: begin
            if (!status.stack_empty) begin
               lo_in   = stk_lo[top_idx];
               hi_in   = stk_hi[top_idx];
               node_in = stk_node[top_idx];
               sp_in   = sp_m1;
            end
         end
         A_RESPOND: begin
            rsp_strobe_in = 1'b1;
            rsp_val_in    = acc_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= LC_W'(1);
         clr_ff        <= '0;
         sp_ff         <= '0;
         acc_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         leaf_count_ff <= leaf_count_in;
         clr_ff        <= clr_in;
         sp_ff         <= sp_in;
         acc_vld_ff    <= acc_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pos_ff     <= pos_in;
      ql_ff      <= ql_in;
      qh_ff      <= qh_in;
      val_ff     <= val_in;
      acc_ff     <= acc_in;
      rsp_val_ff <= rsp_val_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      node_ff    <= node_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_lo[push_idx]   <= mid_p1;
         stk_hi[push_idx]   <= hi_ff;
         stk_node[push_idx] <= right_child;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_ra];
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_max_value = rsp_val_ff;

endmodule

### rtl/segment_tree_range_max.sv
// ----------------------------------------------------------------------------
// segment_tree_range_max: range-maximum segment tree, microcoded, one item in flight
// write: descends to the written leaf (depth 14 at full size) and climbs to the root; ignored if past the tree
// query: depth-first walk, reads only nodes inside the span; strobe as busy falls
// reset: clears all 2*2^ceil(log2 LEAVES_MAX) nodes to -1, busy high throughout
// ----------------------------------------------------------------------------
module segment_tree_range_max #(
   parameter int LEAVES_MAX = stmr_pkg::LEAVES_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // command side
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic        [stmr_pkg::POS_W-1:0] req_position,
   input  logic signed [stmr_pkg::VAL_W-1:0] req_value_in,
   input  logic        [stmr_pkg::POS_W-1:0] req_range_low,
   input  logic        [stmr_pkg::POS_W-1:0] req_range_high,
   // leaf count register
   input  logic                              csr_write_en,
   input  logic        [stmr_pkg::LC_W-1:0]  csr_write_data,
   // result side, one-cycle strobe, cannot be held off
   output logic                              rsp_strobe,
   output logic signed [stmr_pkg::VAL_W-1:0] rsp_max_value
);
   import stmr_pkg::*;

   // control word of the current step, and the flags the jumps test
   ctrl_word_type ctrl;
   status_type    status;

   // step counter and control store
   // an item is taken when the counter sits on the idle step and start is high;
   // after reset the counter runs the clearing step until every node holds -1
   stmr_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   // node memory, current frame (lo, hi, node), frame stack for the query walk,
   // running maximum and the result register
   // writes walk down to the leaf then climb, merging with each sibling;
   // queries walk depth first, pushing the right half of each split node
   stmr_datapath #(
      .LEAVES_MAX (LEAVES_MAX)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .status         (status),
      .req_op         (req_op),
      .req_position   (req_position),
      .req_value_in   (req_value_in),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_max_value  (rsp_max_value)
   );

endmodule

### rtl/stmr_checker.sv
// ----------------------------------------------------------------------------
// stmr_checker
// port-level checks on the command and result channels
// ----------------------------------------------------------------------------
`include "segment_tree_range_max_defines.svh"

module stmr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_strobe,
   input logic signed [stmr_pkg::VAL_W-1:0] rsp_max_value
);

   // a taken item always leaves the block busy on the next cycle
   `STMR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // a result is never strobed in back-to-back cycles
   `STMR_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_strobe, !rsp_strobe)

   // a result only follows a cycle in which the block was busy
   `STMR_ASSERT_SAME(a_rsp_after_busy, clock, reset, rsp_strobe, $past(busy))

   // a strobed result carries a known value
   `STMR_ASSERT_SAME(a_rsp_known, clock, reset, rsp_strobe, !$isunknown(rsp_max_value))

   // reset starts the clearing pass, so no item can be taken straight after it
   `STMR_ASSERT_SAME(a_reset_clears, clock, reset, $past(reset), busy && !rsp_strobe)

endmodule

bind segment_tree_range_max stmr_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_max_value (rsp_max_value)
);

### verif/segment_tree_range_max_tb.sv
// ----------------------------------------------------------------------------
// segment_tree_range_max_tb: self-checking bench for the range-maximum tree
// drives point writes and range queries through the start/busy command port,
// keeps its own copy of the tree to predict every query answer and compares
// each strobed result with the oldest prediction, over several leaf counts
// ----------------------------------------------------------------------------

typedef enum logic {
   OP_WRITE = 1'b0,
   OP_QUERY = 1'b1
} tree_op_type;

typedef struct packed {
   tree_op_type                         op;
   logic        [stmr_pkg::POS_W-1:0]   position;
   logic signed [stmr_pkg::VAL_W-1:0]   value_in;
   logic        [stmr_pkg::POS_W-1:0]   range_low;
   logic        [stmr_pkg::POS_W-1:0]   range_high;
} tree_cmd_type;

// mirror of the tree plus the queue of answers still owed by the block
class range_max_scoreboard;
   localparam int LEAVES      = stmr_pkg::LEAVES_MAX_DEFAULT;
   localparam int NODE_SLOTS  = 4 * LEAVES;

   int                                  node_val[NODE_SLOTS];
   logic [stmr_pkg::LC_W-1:0]           leaf_count;
   logic signed [stmr_pkg::VAL_W-1:0]   owed_max[$];
   int                                  mismatches;
   int                                  answers_checked;

   function new();
      foreach (node_val[i]) node_val[i] = -1;
      leaf_count      = stmr_pkg::LC_W'(1);
      mismatches      = 0;
      answers_checked = 0;
   endfunction

   function void set_leaf_count(logic [stmr_pkg::LC_W-1:0] n);
      leaf_count = n;
   endfunction

   // last position covered by the tree, with zero and oversize clamped
   function int last_leaf();
      int n;
      n = int'(leaf_count);
      if (n == 0) n = 1;
      if (n > LEAVES) n = LEAVES;
      return n - 1;
   endfunction

   function int node_at(int idx);
      return (idx < NODE_SLOTS) ? node_val[idx] : -1;
   endfunction

   function int range_peak(int lo, int hi, int idx, int ql, int qh);
      int mid, a, b;
      if (ql > hi || qh < lo) return -1;
      if (ql <= lo && qh >= hi) return node_at(idx);
      mid = (lo + hi) / 2;
      a   = range_peak(lo, mid, 2 * idx + 1, ql, qh);
      b   = range_peak(mid + 1, hi, 2 * idx + 2, ql, qh);
      return (a > b) ? a : b;
   endfunction

   function void store_leaf(int lo, int hi, int idx, int pos, int v);
      int mid, a, b;
      if (pos < lo || pos > hi) return;
      if (lo == hi) begin
         if (idx < NODE_SLOTS) node_val[idx] = v;
         return;
      end
      mid = (lo + hi) / 2;
      store_leaf(lo, mid, 2 * idx + 1, pos, v);
      store_leaf(mid + 1, hi, 2 * idx + 2, pos, v);
      a = node_at(2 * idx + 1);
      b = node_at(2 * idx + 2);
      if (idx < NODE_SLOTS) node_val[idx] = (a > b) ? a : b;
   endfunction

   function void note_command(tree_cmd_type c);
      if (c.op == OP_WRITE)
         store_leaf(0, last_leaf(), 0, int'(c.position), int'(c.value_in));
      else
         owed_max.insert(owed_max.size(),
                         range_peak(0, last_leaf(), 0, int'(c.range_low),
                                    int'(c.range_high)));
   endfunction

   function void check_answer(logic signed [stmr_pkg::VAL_W-1:0] got);
      logic signed [stmr_pkg::VAL_W-1:0] want;
      if (owed_max.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %0d", $time, got);
         mismatches++;
         return;
      end
      want = owed_max.pop_front();
      answers_checked++;
      if (got !== want) begin
         $display("%0t: max_value mismatch, expected %0d, actual %0d", $time, want, got);
         mismatches++;
      end
   endfunction

   function int owed();
      return owed_max.size();
   endfunction
endclass

module segment_tree_range_max_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int WRITE_SETTLE  = 64;   // a write raises no strobe
   localparam int DRAIN_CYCLES  = 300;
   localparam int PHASE_ITEMS   = 80;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic                                req_op = 1'b0;
   logic        [stmr_pkg::POS_W-1:0]   req_position = '0;
   logic signed [stmr_pkg::VAL_W-1:0]   req_value_in = '0;
   logic        [stmr_pkg::POS_W-1:0]   req_range_low = '0;
   logic        [stmr_pkg::POS_W-1:0]   req_range_high = '0;
   logic                                csr_write_en = 1'b0;
   logic        [stmr_pkg::LC_W-1:0]    csr_write_data = '0;
   logic                                rsp_strobe;
   logic signed [stmr_pkg::VAL_W-1:0]   rsp_max_value;

   range_max_scoreboard tree_sb;
   int                  cycle_count = 0;
   int                  items_sent  = 0;
   int                  idle_pct    = 0;
   int                  settings_run = 0;

   segment_tree_range_max dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_position   (req_position),
      .req_value_in   (req_value_in),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_max_value  (rsp_max_value)
   );

   always #4 clock = ~clock;

   // watchdog, reckoned from the clearing pass plus worst-case items many times over
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[segment_tree_range_max] ERROR");
         $finish;
      end
   end

   // results cannot be held off, so every strobe is taken at the edge ending it
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1 && tree_sb != null)
         tree_sb.check_answer(rsp_max_value);
   end

   // one command: optional idle cycles first, then hold start until busy is low
   task automatic drive_item(tree_cmd_type c);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start          = 1'b1;
      req_op         = c.op;
      req_position   = c.position;
      req_value_in   = c.value_in;
      req_range_low  = c.range_low;
      req_range_high = c.range_high;
      do @(posedge clock); while (busy !== 1'b0);
      tree_sb.note_command(c);
      items_sent++;
   endtask

   // leaf count only changes with the block idle and nothing owed
   task automatic write_leaf_count(logic [stmr_pkg::LC_W-1:0] n);
      @(negedge clock);
      start = 1'b0;
      while (tree_sb.owed() != 0) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      repeat (WRITE_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = n;
      @(negedge clock);
      csr_write_en   = 1'b0;
      tree_sb.set_leaf_count(n);
      settings_run++;
   endtask

   function automatic logic signed [stmr_pkg::VAL_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3, 4: return $signed($urandom_range(0, 400)) - 200;
         default: return $signed($urandom());
      endcase
   endfunction

   // mostly well-formed writes and queries inside the tree, some noise outside it
   function automatic tree_cmd_type random_command(int n);
      tree_cmd_type c;
      int           kind, a, b;
      logic [31:0]  r0, r1, r2;
      kind         = $urandom_range(0, 99);
      r0           = $urandom();
      r1           = $urandom();
      r2           = $urandom();
      c.op         = OP_WRITE;
      c.position   = r0[stmr_pkg::POS_W-1:0];
      c.value_in   = random_value();
      c.range_low  = r1[stmr_pkg::POS_W-1:0];
      c.range_high = r2[stmr_pkg::POS_W-1:0];
      if (kind < 45) begin
         a = $urandom_range(0, n - 1);
         c.position = a[stmr_pkg::POS_W-1:0];
      end else if (kind < 52) begin
         // write anywhere, mostly ignored when the tree is small
      end else if (kind < 85) begin
         c.op = OP_QUERY;
         a = $urandom_range(0, n - 1);
         b = $urandom_range(0, n - 1);
         c.range_low  = (a < b) ? a[stmr_pkg::POS_W-1:0] : b[stmr_pkg::POS_W-1:0];
         c.range_high = (a < b) ? b[stmr_pkg::POS_W-1:0] : a[stmr_pkg::POS_W-1:0];
      end else if (kind < 93) begin
         c.op = OP_QUERY;   // arbitrary span, may run past the tree
      end else begin
         c.op = OP_QUERY;   // empty span
         a = $urandom_range(1, (1 << stmr_pkg::POS_W) - 1);
         b = $urandom_range(0, a - 1);
         c.range_low  = a[stmr_pkg::POS_W-1:0];
         c.range_high = b[stmr_pkg::POS_W-1:0];
      end
      return c;
   endfunction

   function automatic tree_cmd_type wr(int pos, int v);
      return '{OP_WRITE, pos[stmr_pkg::POS_W-1:0], v, '0, '0};
   endfunction

   function automatic tree_cmd_type qr(int lo, int hi);
      return '{OP_QUERY, '0, '0, lo[stmr_pkg::POS_W-1:0], hi[stmr_pkg::POS_W-1:0]};
   endfunction

   initial begin
      // leaf counts for the random phases: zero and oversize clamp, both extremes
      logic [stmr_pkg::LC_W-1:0] phase_leaves[8];
      int total_items;
      int n;

      phase_leaves =
         '{15'd0, 15'd1, 15'd5, 15'd16384, 15'd32767, 15'd100, 15'd2, 15'd12001};
      tree_sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // clearing pass after reset keeps busy high
      while (busy !== 1'b0) @(posedge clock);

      // directed part on an eight-leaf tree
      write_leaf_count(15'd8);
      drive_item(qr(0, 7));                        // freshly cleared tree
      drive_item(wr(0, 32'sh7FFF_FFFF));
      drive_item(wr(7, 32'sh8000_0000));
      drive_item(wr(8, 1000));                     // just past the tree, ignored
      drive_item(wr(16383, 5));                    // far past the tree, ignored
      drive_item(wr(3, -1));
      drive_item(wr(4, 0));
      drive_item(qr(0, 7));
      drive_item(qr(0, 16383));
      drive_item(qr(8, 16383));                    // wholly beyond the tree
      drive_item(qr(7, 7));
      drive_item(qr(5, 2));                        // empty span
      drive_item(qr(16383, 0));                    // empty span, widest
      drive_item(qr(1, 6));
      drive_item(wr(0, 32'sh8000_0000));
      drive_item(qr(0, 0));
      drive_item(wr(5, 123));
      drive_item(qr(4, 5));
      drive_item(qr(0, 3));
      drive_item(qr(1, 7));

      // random phases; the stored nodes carry over between leaf counts
      total_items = PHASE_ITEMS * 8;
      foreach (phase_leaves[p]) begin
         write_leaf_count(phase_leaves[p]);
         n = tree_sb.last_leaf() + 1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // sender idling: light, then heavy, then none
            if (p * PHASE_ITEMS + i < total_items / 3)
               idle_pct = 10;
            else if (p * PHASE_ITEMS + i < 2 * total_items / 3)
               idle_pct = 61;
            else
               idle_pct = 0;
            drive_item(random_command(n));
         end
      end

      @(negedge clock);
      start = 1'b0;
      while (tree_sb.owed() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands over %0d leaf-count settings, %0d query answers checked",
               items_sent, settings_run, tree_sb.answers_checked);
      $display("mismatches %0d, answers still owed %0d", tree_sb.mismatches, tree_sb.owed());
      if (tree_sb.mismatches == 0 && tree_sb.owed() == 0)
         $display("[segment_tree_range_max] OK");
      else
         $display("[segment_tree_range_max] ERROR");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/stmr_pkg.sv
rtl/stmr_sequencer.sv
rtl/stmr_datapath.sv
rtl/segment_tree_range_max.sv
rtl/stmr_checker.sv
verif/segment_tree_range_max_tb.sv
